[rtl/gsbd_pkg.sv]
// Package for the GCR sync hunter and byte decoder.
// Holds shared types, widths, register indexes and the GCR code table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsbd_pkg;

  localparam int unsigned SyncW     = 11;
  localparam int unsigned BlockW    = 9;
  localparam int unsigned RunW      = 11;
  localparam int unsigned BitPosW   = 4;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [RunW-1:0]    RunLimit     = 11'd1024;
  localparam logic [BitPosW-1:0] LastBitPos   = 4'd9;
  localparam logic [SyncW-1:0]   SyncReset    = 11'd40;
  localparam logic [BlockW-1:0]  BlockReset   = 9'd8;
  localparam logic [7:0]         BadCode      = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegSyncLength = 8'd0;
  localparam logic [CfgIndexW-1:0] RegBlockBytes = 8'd1;

  typedef struct packed {
    logic [SyncW-1:0]  sync_run_min;
    logic [BlockW-1:0] block_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       code_error;
    logic       last_byte;
    logic       checksum_ok;
    logic       block_code_error;
  } result_t;

  // Map a 5-bit GCR code to its nibble; invalid codes give BadCode.
  function automatic logic [7:0] gcr_nibble(input logic [4:0] code);
    logic [7:0] nib;
    begin
      case (code)
        5'h09: nib = 8'h08;
        5'h0A: nib = 8'h00;
        5'h0B: nib = 8'h01;
        5'h0D: nib = 8'h0C;
        5'h0E: nib = 8'h04;
        5'h0F: nib = 8'h05;
        5'h12: nib = 8'h02;
        5'h13: nib = 8'h03;
        5'h15: nib = 8'h0F;
        5'h16: nib = 8'h06;
        5'h17: nib = 8'h07;
        5'h19: nib = 8'h09;
        5'h1A: nib = 8'h0A;
        5'h1B: nib = 8'h0B;
        5'h1D: nib = 8'h0D;
        5'h1E: nib = 8'h0E;
        default: nib = BadCode;
      endcase
      return nib;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/gsbd_cfg_regs.sv]
// Configuration registers for the GCR decoder: sync length and block length.
// Depends on gsbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsbd_cfg_regs import gsbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_run_min <= SyncReset;
      cfg.block_bytes  <= BlockReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegSyncLength) begin
        cfg.sync_run_min <= cfg_data[SyncW-1:0];
      end else if (cfg_index == RegBlockBytes) begin
        cfg.block_bytes <= cfg_data[BlockW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/gsbd_in_reg.sv]
// Input register for the raw bit stream.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gsbd_in_reg (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid_s,
  output logic      in_ready_s,
  input  wire logic in_bit_s,
  input  wire logic take,
  output logic      bit_valid,
  output logic      bit_data
);

  // Accept when empty or when the held bit leaves this cycle
  assign in_ready_s = !bit_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
    end else if (in_ready_s) begin
      bit_valid <= in_valid_s;
    end
  end

  // Hold the payload until it is taken
  always_ff @(posedge clk) begin
    if (in_ready_s && in_valid_s) begin
      bit_data <= in_bit_s;
    end
  end

endmodule

`default_nettype wire

[rtl/gsbd_decode.sv]
// Sync hunter, GCR byte assembler and result register.
// Depends on gsbd_pkg for the code table, types and constants.
`timescale 1ns / 1ps
`default_nettype none

module gsbd_decode import gsbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic bit_valid,
  input  wire logic bit_data,
  output logic      take,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  logic              in_block, in_block_next;
  logic [RunW-1:0]   ones_run, ones_run_next;
  logic [9:0]        code_shift, code_shift_next;
  logic [BitPosW-1:0] bit_position, bit_position_next;
  logic [BlockW-1:0] byte_position, byte_position_next;
  logic [7:0]        xor_accumulator, xor_accumulator_next;
  logic              error_seen, error_seen_next;

  logic              run_block;
  logic [9:0]        base_shift;
  logic [BitPosW-1:0] base_bitpos;
  logic [BlockW-1:0] base_bytepos;
  logic [7:0]        base_xor;
  logic              base_err;
  logic [9:0]        shifted;
  logic [7:0]        hi_nib, lo_nib, byte_val, xor_new;
  logic              err, err_all, last, emit;
  logic [BlockW:0]   pos_plus;
  result_t           res_next;

  // Take the held bit when the result slot is free or drains now
  assign take = bit_valid && (!res_valid || res_ready);

  // Block path runs inside a block or on the zero that ends a sync run
  assign run_block = in_block || (!bit_data && (ones_run >= cfg.sync_run_min));

  // A fresh block starts from cleared state
  assign base_shift   = in_block ? code_shift      : '0;
  assign base_bitpos  = in_block ? bit_position    : '0;
  assign base_bytepos = in_block ? byte_position   : '0;
  assign base_xor     = in_block ? xor_accumulator : '0;
  assign base_err     = in_block ? error_seen      : 1'b0;

  assign shifted = {base_shift[8:0], bit_data};

  // Decode both codes; an invalid low code forces the whole byte high
  assign hi_nib   = gcr_nibble(shifted[9:5]);
  assign lo_nib   = gcr_nibble(shifted[4:0]);
  assign err      = (hi_nib == BadCode) || (lo_nib == BadCode);
  assign byte_val = {hi_nib[3:0], 4'h0} | lo_nib;
  assign xor_new  = (base_bytepos != '0) ? (base_xor ^ byte_val) : base_xor;
  assign err_all  = base_err || err;
  assign pos_plus = {1'b0, base_bytepos} + {{BlockW{1'b0}}, 1'b1};
  assign last     = pos_plus >= {1'b0, cfg.block_bytes};
  assign emit     = run_block && (base_bitpos == LastBitPos);

  always_comb begin
    in_block_next        = in_block;
    ones_run_next        = ones_run;
    code_shift_next      = code_shift;
    bit_position_next    = bit_position;
    byte_position_next   = byte_position;
    xor_accumulator_next = xor_accumulator;
    error_seen_next      = error_seen;
    res_next.byte_out         = byte_val;
    res_next.code_error       = err;
    res_next.last_byte        = last;
    res_next.checksum_ok      = last && (xor_new == 8'h00);
    res_next.block_code_error = last && err_all;
    if (run_block) begin
      in_block_next        = 1'b1;
      ones_run_next        = '0;
      code_shift_next      = shifted;
      bit_position_next    = base_bitpos + 4'd1;
      byte_position_next   = base_bytepos;
      xor_accumulator_next = base_xor;
      error_seen_next      = base_err;
      if (emit) begin
        bit_position_next = '0;
        if (last) begin
          // End of block: back to hunting
          in_block_next        = 1'b0;
          code_shift_next      = '0;
          byte_position_next   = '0;
          xor_accumulator_next = '0;
          error_seen_next      = 1'b0;
        end else begin
          byte_position_next   = pos_plus[BlockW-1:0];
          xor_accumulator_next = xor_new;
          error_seen_next      = err_all;
        end
      end
    end else if (bit_data) begin
      // Count ones, saturating
      if (ones_run < RunLimit) begin
        ones_run_next = ones_run + 11'd1;
      end
    end else begin
      ones_run_next = '0;
    end
  end

  // Advance decoder state on each taken bit
  always_ff @(posedge clk) begin
    if (rst) begin
      in_block        <= 1'b0;
      ones_run        <= '0;
      code_shift      <= '0;
      bit_position    <= '0;
      byte_position   <= '0;
      xor_accumulator <= '0;
      error_seen      <= 1'b0;
    end else if (take) begin
      in_block        <= in_block_next;
      ones_run        <= ones_run_next;
      code_shift      <= code_shift_next;
      bit_position    <= bit_position_next;
      byte_position   <= byte_position_next;
      xor_accumulator <= xor_accumulator_next;
      error_seen      <= error_seen_next;
    end
  end

  // Result register: load on a completed byte, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[rtl/gcr_sync_and_byte_decoder.sv]
// GCR sync hunter and 4-to-5 byte decoder, top level.
// Each byte is registered as its tenth bit leaves the input register.
// Throughput: one raw bit per cycle; a held result stalls the input only
// while m_tready is low.
// Reset (rst, synchronous): hunting, registers empty, sync run 40, block 8.
// Depends on gsbd_pkg, gsbd_cfg_regs, gsbd_in_reg, gsbd_decode.
`timescale 1ns / 1ps
`default_nettype none

module gcr_sync_and_byte_decoder import gsbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [0] bit_in, [7:1] zero
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [7:0] byte_out, [8] code_error, [9] checksum_ok, [10] block_code_error
  output logic [15:0]               m_tdata,
  output logic                      m_tlast,   // last_byte
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    take;
  logic    bit_valid;
  logic    bit_data;

  gsbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gsbd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid_s (s_tvalid),
    .in_ready_s (s_tready),
    .in_bit_s   (s_tdata[0]),
    .take       (take),
    .bit_valid  (bit_valid),
    .bit_data   (bit_data)
  );

  gsbd_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bit_valid (bit_valid),
    .bit_data  (bit_data),
    .take      (take),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result request
  assign m_tdata = {5'd0, res.block_code_error, res.checksum_ok, res.code_error, res.byte_out};
  assign m_tlast = res.last_byte;

endmodule

`default_nettype wire
